>>> rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg: shared types and constants of the sector block read cache
// request kinds, result codes, queue entry and result records
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

  localparam int unsigned MAX_REQUEST_BYTES = 16384;
  localparam int unsigned SECTOR_BITS       = 9;
  localparam int unsigned BLOCK_SECTORS_MAX = 4096;

  localparam int unsigned OFF_W  = 32;
  localparam int unsigned LEN_W  = 15;
  localparam int unsigned CAP_W  = 25;
  localparam int unsigned RLEN_W = 25;
  localparam int unsigned COFF_W = 24;
  localparam int unsigned BSEC_W = 13;
  localparam int unsigned BLK_W  = BSEC_W + SECTOR_BITS;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // request queue between classifier and sequencer
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILE_READY    = 2'd0,
    CFG_FILE_SIZE     = 2'd1,
    CFG_BLOCK_SECTORS = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CACHE  = 2'd0,
    ST_REJECT = 2'd1,
    ST_DIRECT = 2'd2,
    ST_DEFER  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    K_REJECT = 2'd0,
    K_EMPTY  = 2'd1,
    K_READ   = 2'd2,
    K_VIEW   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic [OFF_W-1:0]  last_byte;
    logic [CAP_W-1:0]  capacity;
    logic              aligned;
  } job_t;

  typedef struct packed {
    status_e            status;
    logic               way;
    logic               fill;
    logic               seek;
    logic [OFF_W-1:0]   read_start;
    logic [RLEN_W-1:0]  read_length;
    logic [COFF_W-1:0]  copy_offset;
    logic [LEN_W-1:0]   copy_length;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [OFF_W-1:0] file_size;
    logic [BLK_W-1:0] block_bytes;
    logic             clear;
  } cfg_t;

  function automatic logic [OFF_W-1:0] sector_floor(input logic [OFF_W-1:0] a);
    sector_floor = {a[OFF_W-1:SECTOR_BITS], {SECTOR_BITS{1'b0}}};
  endfunction

endpackage

`default_nettype wire

>>> rtl/sbc_front.sv
// ----------------------------------------------------------------------------
// sbc_front: request classifier
// checks a request against the open file and files it into the queue
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_front
  import sbc_pkg::*;
(
  input  wire logic              req_valid_i,
  output      logic              req_ready_o,
  input  wire logic              action_i,
  input  wire logic [OFF_W-1:0]  offset_i,
  input  wire logic [LEN_W-1:0]  length_i,
  input  wire logic [CAP_W-1:0]  capacity_i,
  input  wire logic              aligned_i,
  input  wire logic              file_ready_i,
  input  wire logic [OFF_W-1:0]  file_size_i,
  input  wire logic              q_full_i,
  output      logic              q_push_o,
  output      job_t              q_job_o
);

  logic [OFF_W:0] end_sum;
  logic           reject;

  assign end_sum = {1'b0, offset_i} + (OFF_W+1)'(length_i);
  assign reject  = !file_ready_i || (length_i > LEN_W'(MAX_REQUEST_BYTES)) ||
                   (end_sum > {1'b0, file_size_i});

  always_comb begin
    q_job_o.offset    = offset_i;
    q_job_o.length    = length_i;
    q_job_o.last_byte = end_sum[OFF_W-1:0];
    q_job_o.capacity  = capacity_i;
    q_job_o.aligned   = aligned_i;
    priority if (reject) begin
      q_job_o.kind = K_REJECT;
    end else if (action_i) begin
      q_job_o.kind = K_VIEW;
    end else if (length_i == '0) begin
      q_job_o.kind = K_EMPTY;
    end else begin
      q_job_o.kind = K_READ;
    end
  end

  assign req_ready_o = !q_full_i;
  assign q_push_o    = req_valid_i && !q_full_i;

endmodule

`default_nettype wire

>>> rtl/sbc_queue.sv
// ----------------------------------------------------------------------------
// sbc_queue: short request queue
// holds classified requests until the sequencer takes them
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_queue
  import sbc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t din_i,
  input  wire logic pop_i,
  output      job_t dout_o,
  output      logic full_o,
  output      logic empty_o
);

  job_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= din_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sbc_back.sv
// ----------------------------------------------------------------------------
// sbc_back: cache sequencer
// owns the way tags, lru bit and file position, walks segments, emits beats
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_back
  import sbc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic q_empty_i,
  input  wire job_t q_job_i,
  output      logic q_pop_o,
  input  wire logic out_ready_i,
  output      logic out_valid_o,
  output      res_t out_res_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOOK  = 8'b0000_0010,
    S_FILL  = 8'b0000_0100,
    S_SEG   = 8'b0000_1000,
    S_VLOOK = 8'b0001_0000,
    S_VDEC  = 8'b0010_0000,
    S_VFIN  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  job_t              job_q, job_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic              sel_q, sel_d;
  logic              miss_q, miss_d;
  logic              seek_q, seek_d;
  logic [OFF_W-1:0]  mstart_q, mstart_d;
  logic [OFF_W-1:0]  fsub_q, fsub_d;
  logic [BLK_W-1:0]  n_q, n_d;
  logic [OFF_W-1:0]  vend_q, vend_d;
  logic [OFF_W-1:0]  span_q, span_d;
  res_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_res_q, out_res_d;

  logic [1:0]        way_valid_q, way_valid_d;
  logic [OFF_W-1:0]  way_start_q [2];
  logic [OFF_W-1:0]  way_start_d [2];
  logic [OFF_W-1:0]  way_end_q [2];
  logic [OFF_W-1:0]  way_end_d [2];
  logic              victim_q, victim_d;
  logic [OFF_W-1:0]  pos_q, pos_d;

  logic [1:0]        hit, vhit;

  // read hit: segment start inside the way; view hit: whole request inside
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      hit[i]  = way_valid_q[i] && (off_q >= way_start_q[i]) && (off_q < way_end_q[i]);
      vhit[i] = way_valid_q[i] && (off_q >= way_start_q[i]) &&
                (job_q.last_byte <= way_end_q[i]);
    end
  end

  always_comb begin
    logic [BLK_W-1:0] n;
    logic [OFF_W-1:0] span;
    logic [LEN_W-1:0] seg;
    logic [OFF_W:0]   vsum;
    logic [OFF_W:0]   vend;
    logic             vway;

    state_d     = state_q;
    job_d       = job_q;
    off_d       = off_q;
    left_d      = left_q;
    sel_d       = sel_q;
    miss_d      = miss_q;
    seek_d      = seek_q;
    mstart_d    = mstart_q;
    fsub_d      = fsub_q;
    n_d         = n_q;
    vend_d      = vend_q;
    span_d      = span_q;
    res_d       = res_q;
    out_res_d   = out_res_q;
    way_valid_d = way_valid_q;
    way_start_d = way_start_q;
    way_end_d   = way_end_q;
    victim_d    = victim_q;
    pos_d       = pos_q;
    q_pop_o     = 1'b0;

    n    = (fsub_q > OFF_W'(cfg_i.block_bytes)) ? cfg_i.block_bytes : fsub_q[BLK_W-1:0];
    span = way_end_q[sel_q] - off_q;
    seg  = (span >= OFF_W'(left_q)) ? left_q : span[LEN_W-1:0];
    vsum = {1'b0, job_q.last_byte} + (OFF_W+1)'((1 << SECTOR_BITS) - 1);
    vend = {vsum[OFF_W:SECTOR_BITS], {SECTOR_BITS{1'b0}}};
    vway = !vhit[0];

    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_job_i;
          off_d   = q_job_i.offset;
          left_d  = q_job_i.length;
          res_d   = '0;
          res_d.last = 1'b1;
          unique case (q_job_i.kind)
            K_REJECT: begin
              res_d.status = ST_REJECT;
              state_d      = S_EMIT;
            end
            K_EMPTY: begin
              res_d.status = ST_CACHE;
              state_d      = S_EMIT;
            end
            K_READ:  state_d = S_LOOK;
            K_VIEW:  state_d = S_VLOOK;
            default: state_d = S_IDLE;
          endcase
        end
      end

      // pick the serving way, way 1 wins when both hold the segment
      S_LOOK: begin
        miss_d   = !(hit[0] || hit[1]);
        sel_d    = hit[1] ? 1'b1 : (hit[0] ? 1'b0 : victim_q);
        mstart_d = sector_floor(off_q);
        fsub_d   = cfg_i.file_size - sector_floor(off_q);
        state_d  = (hit[0] || hit[1]) ? S_SEG : S_FILL;
      end

      // load the victim way, clamped to the file end
      S_FILL: begin
        n_d                = n;
        way_valid_d[sel_q] = 1'b1;
        way_start_d[sel_q] = mstart_q;
        way_end_d[sel_q]   = mstart_q + OFF_W'(n);
        seek_d             = (mstart_q != pos_q);
        pos_d              = mstart_q + OFF_W'(n);
        state_d            = S_SEG;
      end

      S_SEG: begin
        res_d.status      = ST_CACHE;
        res_d.way         = sel_q;
        res_d.fill        = miss_q;
        res_d.seek        = miss_q && seek_q;
        res_d.read_start  = miss_q ? mstart_q : '0;
        res_d.read_length = miss_q ? RLEN_W'(n_q) : '0;
        res_d.copy_offset = COFF_W'(off_q - way_start_q[sel_q]);
        res_d.copy_length = seg;
        res_d.last        = (seg == left_q);
        victim_d          = !sel_q;
        left_d            = left_q - seg;
        off_d             = off_q + OFF_W'(seg);
        state_d           = S_EMIT;
      end

      S_VLOOK: begin
        if (vhit[0] || vhit[1]) begin
          res_d             = '0;
          res_d.status      = ST_CACHE;
          res_d.way         = vway;
          res_d.copy_offset = COFF_W'(off_q - way_start_q[vway]);
          res_d.copy_length = job_q.length;
          res_d.last        = 1'b1;
          victim_d          = !vway;
          state_d           = S_EMIT;
        end else begin
          vend_d   = (vend > {1'b0, cfg_i.file_size}) ? cfg_i.file_size : vend[OFF_W-1:0];
          mstart_d = sector_floor(off_q);
          state_d  = S_VDEC;
        end
      end

      S_VDEC: begin
        span_d  = vend_q - mstart_q;
        seek_d  = (mstart_q != pos_q);
        state_d = S_VFIN;
      end

      // direct read only into a roomy, aligned caller buffer; otherwise defer
      S_VFIN: begin
        res_d             = '0;
        res_d.copy_length = job_q.length;
        res_d.last        = 1'b1;
        if ((span_q > OFF_W'(job_q.capacity)) || !job_q.aligned) begin
          res_d.status = ST_DEFER;
        end else begin
          res_d.status      = ST_DIRECT;
          res_d.seek        = seek_q;
          res_d.read_start  = mstart_q;
          res_d.read_length = span_q[RLEN_W-1:0];
          res_d.copy_offset = COFF_W'(off_q[SECTOR_BITS-1:0]);
          pos_d             = vend_q;
        end
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          state_d     = res_q.last ? S_IDLE : S_LOOK;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // open or close of the file empties both ways
    if (cfg_i.clear) begin
      way_valid_d = '0;
      victim_d    = 1'b0;
      pos_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      way_valid_q <= '0;
      victim_q    <= 1'b0;
      pos_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      way_valid_q <= way_valid_d;
      victim_q    <= victim_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    off_q       <= off_d;
    left_q      <= left_d;
    sel_q       <= sel_d;
    miss_q      <= miss_d;
    seek_q      <= seek_d;
    mstart_q    <= mstart_d;
    fsub_q      <= fsub_d;
    n_q         <= n_d;
    vend_q      <= vend_d;
    span_q      <= span_d;
    res_q       <= res_d;
    out_res_q   <= out_res_d;
    way_start_q <= way_start_d;
    way_end_q   <= way_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire

>>> rtl/two_way_sector_block_read_cache.sv
// ----------------------------------------------------------------------------
// two_way_sector_block_read_cache: two-way lru read cache control for a file
// read: each segment passes the look, fill (on a miss only), segment and emit states of the sequencer
// throughput: one request in sequence; the 2-deep queue takes requests meanwhile
// reset: registers to defaults, file closed, both ways empty, way 0 victim first
// ----------------------------------------------------------------------------
`default_nettype none

module two_way_sector_block_read_cache
  import sbc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  // request stream
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // offset[31:0], length[46:32], capacity[71:47], buffer_aligned[72], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // action[0]
  input  wire logic                   s_axis_tuser,

  // result stream
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // way[0], fill[1], seek[2], read_start[34:3], read_length[59:35],
  // copy_offset[83:60], copy_length[98:84], zero pad
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output      logic [1:0]             m_axis_tuser,
  output      logic                   m_axis_tlast,

  // register writes
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // configuration registers
  logic              file_ready_q;
  logic [OFF_W-1:0]  file_size_q;
  logic [BSEC_W-1:0] block_sectors_q;
  logic [BSEC_W-1:0] bsec_clamped;

  // queue hookup
  logic q_push, q_pop, q_full, q_empty;
  job_t q_job_in, q_job_out;

  cfg_t cfg;
  res_t res;

  // writes are always taken; the user must write only while the block is idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  // way size: zero acts as one sector, anything above the limit as the limit
  always_comb begin
    priority if (cfg_data_i[BSEC_W-1:0] == '0) begin
      bsec_clamped = BSEC_W'(1);
    end else if (cfg_data_i[BSEC_W-1:0] > BSEC_W'(BLOCK_SECTORS_MAX)) begin
      bsec_clamped = BSEC_W'(BLOCK_SECTORS_MAX);
    end else begin
      bsec_clamped = cfg_data_i[BSEC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_ready_q    <= 1'b0;
      file_size_q     <= '0;
      block_sectors_q <= BSEC_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FILE_READY:    file_ready_q    <= cfg_data_i[0];
        CFG_FILE_SIZE:     file_size_q     <= cfg_data_i[OFF_W-1:0];
        CFG_BLOCK_SECTORS: block_sectors_q <= bsec_clamped;
        default: ; // unknown index is dropped
      endcase
    end
  end

  // config view for the sequencer; a file_ready write also flushes the ways
  assign cfg.file_size   = file_size_q;
  assign cfg.block_bytes = {block_sectors_q, {SECTOR_BITS{1'b0}}};
  assign cfg.clear       = cfg_valid_i && (cfg_index_i == CFG_FILE_READY);

  // front: classify the request beat and queue it
  sbc_front u_front (
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .action_i     (s_axis_tuser),
    .offset_i     (s_axis_tdata[31:0]),
    .length_i     (s_axis_tdata[46:32]),
    .capacity_i   (s_axis_tdata[71:47]),
    .aligned_i    (s_axis_tdata[72]),
    .file_ready_i (file_ready_q),
    .file_size_i  (file_size_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_job_o      (q_job_in)
  );

  // decoupling queue so either side can stall on its own
  sbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (q_job_in),
    .pop_i   (q_pop),
    .dout_o  (q_job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: segment walk, way fills, view decisions and the output register
  sbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_job_i     (q_job_out),
    .q_pop_o     (q_pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res)
  );

  // pack the result beat
  assign m_axis_tdata = {5'b0, res.copy_length, res.copy_offset, res.read_length,
                         res.read_start, res.seek, res.fill, res.way};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the two-way sector block read cache
// A request stream with random bursts and gaps and a result stream with a
// changing stall pattern run through several register settings. A scoreboard
// predicts the result beats of every accepted request and checks each result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import sbc_pkg::*;

  localparam bit ACT_READ = 1'b0;
  localparam bit ACT_VIEW = 1'b1;
  // index past the last register, the block has to ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  // quiet cycles allowed after the last expected result before a register write
  localparam int SETTLE_CYCLES = 16;
  // cycles without any beat on any channel before the run is given up
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic             action;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic [CAP_W-1:0] capacity;
    logic             aligned;
  } request_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_HICCUP} rx_mode_e;

  // scoreboard: own copy of the way table, file position and registers
  class lru_cache_scoreboard;
    localparam bit [63:0] SECTOR_MASK = (64'd1 << SECTOR_BITS) - 64'd1;

    bit          file_open;
    bit [31:0]   file_bytes;
    int unsigned way_sectors;
    bit          way_full[2];
    bit [31:0]   way_base[2];
    bit [21:0]   way_bytes[2];
    bit          victim;
    bit [31:0]   disk_pos;
    res_t        expected_results[$];
    int          errors;

    function new();
      file_open   = 1'b0;
      file_bytes  = '0;
      way_sectors = 1;
      errors      = 0;
      empty_ways();
    endfunction

    function void empty_ways();
      for (int i = 0; i < 2; i++) begin
        way_full[i]  = 1'b0;
        way_base[i]  = '0;
        way_bytes[i] = '0;
      end
      victim   = 1'b0;
      disk_pos = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      logic [BSEC_W-1:0] sectors;
      case (idx)
        CFG_FILE_READY: begin
          file_open = data[0];
          empty_ways();
        end
        CFG_FILE_SIZE: file_bytes = data;
        CFG_BLOCK_SECTORS: begin
          sectors = data[BSEC_W-1:0];
          if (sectors == 0) way_sectors = 1;
          else if (sectors > BLOCK_SECTORS_MAX) way_sectors = BLOCK_SECTORS_MAX;
          else way_sectors = 32'(sectors);
        end
        default: ;
      endcase
    endfunction

    function void push_result(status_e st, bit w, bit f, bit sk, bit [31:0] rs,
                              bit [24:0] rl, bit [23:0] co, bit [14:0] cl, bit lst);
      res_t r;
      r.status      = st;
      r.way         = w;
      r.fill        = f;
      r.seek        = sk;
      r.read_start  = rs;
      r.read_length = rl;
      r.copy_offset = co;
      r.copy_length = cl;
      r.last        = lst;
      expected_results.push_back(r);
    endfunction

    function void note_request(request_t q);
      bit [63:0]   pos, req_end, way_end, seg, view_start, view_end;
      bit [31:0]   fill_start, fill_len, rs, rl;
      bit          fill, seek;
      int unsigned left, blk;
      int          hit;

      req_end = 64'(q.offset) + 64'(q.length);
      blk     = way_sectors << SECTOR_BITS;
      if (!file_open || q.length > MAX_REQUEST_BYTES || req_end > 64'(file_bytes)) begin
        push_result(ST_REJECT, 0, 0, 0, 0, 0, 0, 0, 1);
      end else if (q.action == ACT_READ) begin
        pos  = 64'(q.offset);
        left = 32'(q.length);
        if (left == 0) push_result(ST_CACHE, 0, 0, 0, 0, 0, 0, 0, 1);
        while (left > 0) begin
          // the higher way wins when both hold the byte
          hit = -1;
          for (int i = 0; i < 2; i++) begin
            way_end = 64'(way_base[i]) + 64'(way_bytes[i]);
            if (way_full[i] && pos >= 64'(way_base[i]) && pos < way_end) hit = i;
          end
          fill = 1'b0;
          seek = 1'b0;
          rs   = '0;
          rl   = '0;
          if (hit < 0) begin
            // load the victim from the sector start, clamped to the file end
            fill_start = pos[31:0] & ~SECTOR_MASK[31:0];
            fill_len   = file_bytes - fill_start;
            if (fill_len > blk) fill_len = blk;
            hit            = int'(victim);
            fill           = 1'b1;
            seek           = (fill_start != disk_pos);
            rs             = fill_start;
            rl             = fill_len;
            disk_pos       = fill_start + fill_len;
            way_full[hit]  = 1'b1;
            way_base[hit]  = fill_start;
            way_bytes[hit] = fill_len[21:0];
          end
          victim = (hit == 0);
          seg = 64'(way_base[hit]) + 64'(way_bytes[hit]) - pos;
          if (seg > 64'(left)) seg = 64'(left);
          left -= seg[31:0];
          push_result(ST_CACHE, bit'(hit), fill, seek, rs, rl[24:0],
                      24'(pos - 64'(way_base[hit])), seg[14:0], left == 0);
          pos += seg;
        end
      end else begin
        // a view is served from cache only if one way holds all of it, way 0 first
        hit = -1;
        for (int i = 1; i >= 0; i--) begin
          way_end = 64'(way_base[i]) + 64'(way_bytes[i]);
          if (way_full[i] && q.offset >= way_base[i] && req_end <= way_end) hit = i;
        end
        if (hit >= 0) begin
          victim = (hit == 0);
          push_result(ST_CACHE, bit'(hit), 0, 0, 0, 0, 24'(q.offset - way_base[hit]),
                      q.length, 1);
        end else begin
          view_start = 64'(q.offset) & ~SECTOR_MASK;
          view_end   = (req_end + SECTOR_MASK) & ~SECTOR_MASK;
          if (view_end > 64'(file_bytes)) view_end = 64'(file_bytes);
          if (view_end - view_start > 64'(q.capacity) || !q.aligned) begin
            push_result(ST_DEFER, 0, 0, 0, 0, 0, 0, q.length, 1);
          end else begin
            push_result(ST_DIRECT, 0, 0, view_start[31:0] != disk_pos, view_start[31:0],
                        25'(view_end - view_start), 24'(64'(q.offset) - view_start),
                        q.length, 1);
            disk_pos = view_end[31:0];
          end
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t result %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t result beat with nothing pending: expected none, actual %h",
                 $time, got);
      end else begin
        want = expected_results.pop_front();
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("way", 32'(want.way), 32'(got.way));
        compare_field("fill", 32'(want.fill), 32'(got.fill));
        compare_field("seek", 32'(want.seek), 32'(got.seek));
        compare_field("read_start", want.read_start, got.read_start);
        compare_field("read_length", 32'(want.read_length), 32'(got.read_length));
        compare_field("copy_offset", 32'(want.copy_offset), 32'(got.copy_offset));
        compare_field("copy_length", 32'(want.copy_length), 32'(got.copy_length));
        compare_field("last", 32'(want.last), 32'(got.last));
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // offset, length, capacity, buffer_aligned from bit 0 up, zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // action
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // way, fill, seek, read_start, read_length, copy_offset, copy_length, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // status
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  lru_cache_scoreboard sb;
  res_t                got_beat;
  int                  burst_left = 0;
  int                  quiet_cycles = 0;
  rx_mode_e            rx_mode = RX_OPEN;
  int                  rx_left = 0;
  int unsigned         rx_tick = 0;

  two_way_sector_block_read_cache uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // result side: stall pattern switches between open, coin flip, one in four
  // and rare hiccups, each mode held for a random stretch
  always @(negedge clk_i) begin
    rx_tick++;
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:  m_axis_tready = 1'b1;
      RX_COIN:  m_axis_tready = 1'($urandom_range(0, 1));
      RX_SLOW:  m_axis_tready = (rx_tick % 4 == 0);
      default:  m_axis_tready = ($urandom_range(0, 7) != 0);
    endcase
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_beat.status      = status_e'(m_axis_tuser);
      got_beat.way         = m_axis_tdata[0];
      got_beat.fill        = m_axis_tdata[1];
      got_beat.seek        = m_axis_tdata[2];
      got_beat.read_start  = m_axis_tdata[34:3];
      got_beat.read_length = m_axis_tdata[59:35];
      got_beat.copy_offset = m_axis_tdata[83:60];
      got_beat.copy_length = m_axis_tdata[98:84];
      got_beat.last        = m_axis_tlast;
      sb.check_result(got_beat);
    end
  end

  // watchdog: any beat on any channel counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // one request beat; bursts of random length with random gaps in between
  task automatic issue(bit act, bit [OFF_W-1:0] off, bit [LEN_W-1:0] len,
                       bit [CAP_W-1:0] cap, bit al);
    request_t req;
    int       gap;
    req = '{action: act, offset: off, length: len, capacity: cap, aligned: al};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = req.action;
    s_axis_tdata  = IN_TDATA_W'({req.aligned, req.capacity, req.length, req.offset});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(req);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // stop sending, let every pending result come out, then give the block time
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly in-file requests clustered around a moving spot so ways get reused,
  // the rest just past the file end or plain noise
  task automatic run_random_phase(int unsigned count);
    bit [63:0]        span, off64, region;
    int unsigned      len, blk_bytes, roll, lr;
    bit               act, al;
    bit [CAP_W-1:0]   cap;
    region    = '0;
    blk_bytes = sb.way_sectors << SECTOR_BITS;
    span      = 64'(sb.file_bytes);
    repeat (count) begin
      act  = 1'($urandom_range(0, 1));
      al   = ($urandom_range(0, 4) != 0);
      roll = $urandom_range(0, 9);
      if (roll < 6) cap = CAP_W'($urandom_range(0, 20000));
      else if (roll < 8) cap = CAP_W'($urandom_range(0, 1024));
      else if (roll == 8) cap = CAP_W'($urandom_range(0, 16777216));
      else cap = CAP_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
        lr = $urandom_range(0, 99);
        if (lr < 55) len = $urandom_range(0, 700);
        else if (lr < 85) len = $urandom_range(0, 4096);
        else if (lr < 95) len = $urandom_range(4096, MAX_REQUEST_BYTES);
        else len = MAX_REQUEST_BYTES;
        if (64'(len) > span) len = span[31:0];
        if ($urandom_range(0, 9) == 0) region = 64'({$urandom}) % (span + 64'd1);
        off64 = (region + 64'($urandom_range(0, 3 * blk_bytes))) % (span - 64'(len) + 64'd1);
      end else if (roll < 90) begin
        len   = $urandom_range(1, 2000);
        off64 = span - 64'(len) + 64'($urandom_range(1, 600));
      end else begin
        len   = $urandom_range(0, (1 << LEN_W) - 1);
        off64 = 64'({$urandom});
      end
      issue(act, off64[31:0], len[LEN_W-1:0], cap, al);
    end
  endtask

  initial begin
    bit [31:0]   sz;
    bit [12:0]   bs;
    bit          rdy;
    int unsigned n;

    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // no file open yet
    issue(ACT_READ, 0, 1, 0, 1);
    wait_idle();

    // small file, one-sector ways
    write_reg(CFG_FILE_SIZE, 5000);
    write_reg(CFG_BLOCK_SECTORS, 1);
    write_reg(CFG_FILE_READY, 1);
    issue(ACT_READ, 0, 0, 0, 1);                  // empty read
    issue(ACT_READ, 100, 1000, 0, 1);             // three fills across sectors
    issue(ACT_READ, 1000, 100, 0, 1);             // hits in both ways
    issue(ACT_VIEW, 1030, 100, 1024, 1);          // view held whole by one way
    issue(ACT_VIEW, 2000, 600, 4096, 1);          // direct read
    issue(ACT_VIEW, 4900, 100, 512, 1);           // direct span clamped to file end
    issue(ACT_VIEW, 2000, 600, 4096, 0);          // unaligned buffer defers
    issue(ACT_VIEW, 3000, 100, 0, 1);             // buffer too small defers
    issue(ACT_READ, 5000, 0, 0, 1);               // empty read at the file end
    issue(ACT_READ, 4990, 11, 0, 1);              // runs past the file end
    issue(ACT_READ, 0, MAX_REQUEST_BYTES + 1, 0, 1);  // too long
    issue(ACT_VIEW, 0, 15'h7FFF, 25'h1FF_FFFF, 1);    // longest length field
    issue(ACT_READ, 4608, 392, 0, 1);             // fill clamped to file end
    issue(ACT_READ, 32'hFFFF_FFFF, 1, 0, 1);      // highest offset
    issue(ACT_VIEW, 4999, 1, 25'h1FF_FFFF, 1);    // last byte of the file
    wait_idle();

    // overlapping ways after a block size change
    write_reg(CFG_FILE_SIZE, 20000);
    write_reg(CFG_BLOCK_SECTORS, 1);
    write_reg(CFG_FILE_READY, 1);
    issue(ACT_READ, 1024, 1, 0, 1);
    wait_idle();
    write_reg(CFG_BLOCK_SECTORS, 4);
    issue(ACT_READ, 0, 1, 0, 1);                  // way 1 now covers way 0 too
    issue(ACT_READ, 1100, 10, 0, 1);              // both hold it, way 1 serves a read
    issue(ACT_VIEW, 1100, 10, 0, 0);              // way 0 serves a view
    issue(ACT_READ, 1, MAX_REQUEST_BYTES, 0, 1);  // longest read
    wait_idle();
    write_reg(CFG_SPARE_INDEX, $urandom);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin sz = 5000;         bs = 13'd0;    rdy = 1'b1; n = 70; end
        1: begin sz = 32'hFFFF_FFFF; bs = 13'h1FFF; rdy = 1'b1; n = 80; end
        2: begin sz = 0;            bs = 13'd4096; rdy = 1'b1; n = 20; end
        3: begin sz = 40000;        bs = 13'd3;    rdy = 1'b1; n = 80; end
        4: begin sz = 1000000;      bs = 13'd17;   rdy = 1'b0; n = 20; end
        5: begin sz = $urandom;     bs = 13'($urandom_range(1, 64)); rdy = 1'b1; n = 80; end
        default: begin sz = 70000;  bs = 13'd2;    rdy = 1'b1; n = 80; end
      endcase
      // upper data bits above the sector count are don't care
      write_reg(CFG_FILE_SIZE, sz);
      write_reg(CFG_BLOCK_SECTORS, {19'($urandom), bs});
      write_reg(CFG_FILE_READY, {31'($urandom), rdy});
      run_random_phase(n);
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

`default_nettype wire
